### sv/rau_pkg.sv
package rau_pkg;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_MUL = 3'd1;
   localparam logic [2:0] CMD_DIV = 3'd2;
   localparam logic [2:0] CMD_LT  = 3'd3;
   localparam logic [2:0] CMD_EQ  = 3'd4;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_DIV0 = 2'd1;
   localparam logic [1:0] STAT_OVF  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_PREP,
      S_GPRE,
      S_GLOOP,
      S_DIVT,
      S_DIVB,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        a_negative;
      logic [31:0] a_top;
      logic [31:0] a_bottom;
      logic        b_negative;
      logic [31:0] b_top;
      logic [31:0] b_bottom;
   } req_type;

   typedef struct packed {
      logic        res_negative;
      logic [31:0] res_top;
      logic [31:0] res_bottom;
      logic        truth;
      logic [1:0]  status;
   } rsp_type;

endpackage

### sv/rau_mul.sv
module rau_mul #(
   parameter int MAG_BITS = 32
) (
   input  logic                      clock,
   input  logic [MAG_BITS-1:0]       op_a,
   input  logic [MAG_BITS-1:0]       op_b,
   output logic [2*MAG_BITS-1:0]     product
);

   logic [2*MAG_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign product = prod_ff;

endmodule

### sv/rau_div.sv
module rau_div #(
   parameter int MAG_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2*MAG_BITS:0]     dividend,
   input  logic [2*MAG_BITS-1:0]   divisor,
   output logic                    done,
   output logic [2*MAG_BITS:0]     quotient
);

   localparam int P  = 2 * MAG_BITS;
   localparam int N  = P + 1;
   localparam int CW = $clog2(N);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [P-1:0]  rem_ff, rem_in;
   logic [N-1:0]  quo_ff, quo_in;
   logic [P-1:0]  d_ff, d_in;
   logic [P:0]    rem_sh;
   logic [P:0]    rem_sub;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[N-1]};
      rem_sub = rem_sh - {1'b0, d_ff};
      ge      = rem_sh >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         d_in    = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[P-1:0] : rem_sh[P-1:0];
         quo_in = {quo_ff[N-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      d_ff   <= d_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, multiply, divide, less-than and equal on
// sign-magnitude rationals, with gcd reduction of arithmetic results.
// Request channel req_valid/req_stall/req_data: one operation per transfer.
// Result channel rsp_valid/rsp_stall/rsp_data: one result per request,
// in request order.
// Work: three products on one shared MAG_BITS x MAG_BITS multiplier, then
// for add/multiply/divide a binary gcd on one shared compare/subtract unit
// and two restoring divisions by the gcd on one divider. Compares and
// errors skip the gcd and the divisions. One operation is in work at a
// time; req_stall is high from acceptance until the result is staged.
// A finished result waits in an output register while rsp_stall is high;
// the next request may be taken meanwhile, and the following result waits.
// Reset (synchronous) empties the output register and returns to idle.
module rational_arithmetic_unit #(
   parameter int MAG_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rau_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rau_pkg::rsp_type  rsp_data
);

   localparam int W  = MAG_BITS;
   localparam int P  = 2 * W;
   localparam int N  = P + 1;
   localparam int KW = $clog2(P + 1);

   rau_pkg::state_type state_ff, state_in;

   logic [2:0]   cmd_ff, cmd_in;
   logic         an_ff, an_in, bn_ff, bn_in, neg_ff, neg_in, zden_ff, zden_in;
   logic [W-1:0] at_ff, at_in, ab_ff, ab_in, bt_ff, bt_in, bb_ff, bb_in;
   logic [P-1:0] x_ff, x_in, y_ff, y_in, bot_ff, bot_in, v_ff, v_in, g_ff, g_in;
   logic [N-1:0] num_ff, num_in, u_ff, u_in, qtop_ff, qtop_in;
   logic [KW-1:0] k_ff, k_in;
   rau_pkg::rsp_type res_ff, res_in, rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [W-1:0] mul_a, mul_b;
   logic [P-1:0] prod;
   logic         div_start, div_done;
   logic [N-1:0] div_dividend, div_quo;
   logic [P-1:0] div_divisor;

   logic         accept, out_free;
   logic [N-1:0] sum, num_c;
   logic         neg_c, lt_c, eq_c, x_ge_y;
   logic [P-1:0] g_c;
   logic [W-1:0] rat, rab, rbt, rbb;

   rau_mul #(.MAG_BITS(W)) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   rau_div #(.MAG_BITS(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !(rsp_valid_ff && rsp_stall);
   assign req_stall = (state_ff != rau_pkg::S_IDLE);

   assign rat = req_data.a_top[W-1:0];
   assign rab = req_data.a_bottom[W-1:0];
   assign rbt = req_data.b_top[W-1:0];
   assign rbb = req_data.b_bottom[W-1:0];

   assign sum    = {1'b0, x_ff} + {1'b0, y_ff};
   assign x_ge_y = x_ff >= y_ff;
   assign g_c    = u_ff[P-1:0] << k_ff;

   always_comb begin
      num_c = {1'b0, x_ff};
      neg_c = an_ff ^ bn_ff;
      if (cmd_ff == rau_pkg::CMD_ADD) begin
         if (an_ff == bn_ff) begin
            num_c = sum;
            neg_c = an_ff;
         end else if (x_ge_y) begin
            num_c = {1'b0, x_ff - y_ff};
            neg_c = an_ff;
         end else begin
            num_c = {1'b0, y_ff - x_ff};
            neg_c = bn_ff;
         end
      end
      if (an_ff && !bn_ff)
         lt_c = 1'b1;
      else if (!an_ff && bn_ff)
         lt_c = 1'b0;
      else if (an_ff)
         lt_c = x_ff > y_ff;
      else
         lt_c = x_ff < y_ff;
      eq_c = (an_ff == bn_ff) && (x_ff == y_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::S_IDLE:  if (accept) state_in = rau_pkg::S_MUL0;
         rau_pkg::S_MUL0:  state_in = rau_pkg::S_MUL1;
         rau_pkg::S_MUL1:  state_in = rau_pkg::S_MUL2;
         rau_pkg::S_MUL2:  state_in = rau_pkg::S_PREP;
         rau_pkg::S_PREP: begin
            if (cmd_ff > rau_pkg::CMD_EQ || zden_ff
                || (cmd_ff == rau_pkg::CMD_DIV && bt_ff == '0)
                || cmd_ff == rau_pkg::CMD_LT || cmd_ff == rau_pkg::CMD_EQ
                || num_c == '0)
               state_in = rau_pkg::S_DONE;
            else
               state_in = rau_pkg::S_GPRE;
         end
         rau_pkg::S_GPRE:  if (u_ff[0] || v_ff[0]) state_in = rau_pkg::S_GLOOP;
         rau_pkg::S_GLOOP: if (v_ff == '0) state_in = rau_pkg::S_DIVT;
         rau_pkg::S_DIVT:  if (div_done) state_in = rau_pkg::S_DIVB;
         rau_pkg::S_DIVB:  if (div_done) state_in = rau_pkg::S_DONE;
         rau_pkg::S_DONE:  if (out_free) state_in = rau_pkg::S_IDLE;
         default:          state_in = rau_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in = cmd_ff; an_in = an_ff; bn_in = bn_ff; neg_in = neg_ff;
      zden_in = zden_ff;
      at_in = at_ff; ab_in = ab_ff; bt_in = bt_ff; bb_in = bb_ff;
      x_in = x_ff; y_in = y_ff; bot_in = bot_ff; v_in = v_ff; g_in = g_ff;
      num_in = num_ff; u_in = u_ff; qtop_in = qtop_ff; k_in = k_ff;
      res_in = res_ff; rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a = at_ff; mul_b = bb_ff;
      div_start = 1'b0;
      div_dividend = num_ff;
      div_divisor  = g_ff;
      case (state_ff)
         rau_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in  = req_data.cmd;
               zden_in = (rab == '0) || (rbb == '0);
               an_in = req_data.a_negative && (rat != '0);
               bn_in = req_data.b_negative && (rbt != '0);
               at_in = rat;
               bt_in = rbt;
               ab_in = (rat == '0) ? W'(1) : rab;
               bb_in = (rbt == '0) ? W'(1) : rbb;
            end
         end
         rau_pkg::S_MUL0: begin
            mul_a = at_ff;
            mul_b = (cmd_ff == rau_pkg::CMD_MUL) ? bt_ff : bb_ff;
         end
         rau_pkg::S_MUL1: begin
            mul_a = bt_ff;
            mul_b = ab_ff;
            x_in  = prod;
         end
         rau_pkg::S_MUL2: begin
            mul_a = ab_ff;
            mul_b = (cmd_ff == rau_pkg::CMD_DIV) ? bt_ff : bb_ff;
            y_in  = prod;
         end
         rau_pkg::S_PREP: begin
            res_in = '0;
            if (cmd_ff > rau_pkg::CMD_EQ) begin
               res_in = '0;
            end else if (zden_ff || (cmd_ff == rau_pkg::CMD_DIV && bt_ff == '0)) begin
               res_in.status = rau_pkg::STAT_DIV0;
            end else if (cmd_ff == rau_pkg::CMD_LT) begin
               res_in.truth = lt_c;
            end else if (cmd_ff == rau_pkg::CMD_EQ) begin
               res_in.truth = eq_c;
            end else if (num_c == '0) begin
               res_in.res_bottom = 32'd1;
            end else begin
               num_in = num_c;
               neg_in = neg_c;
               bot_in = prod;
               u_in   = num_c;
               v_in   = prod;
               k_in   = '0;
            end
         end
         rau_pkg::S_GPRE: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end
         end
         rau_pkg::S_GLOOP: begin
            if (v_ff == '0) begin
               g_in         = g_c;
               div_start    = 1'b1;
               div_dividend = num_ff;
               div_divisor  = g_c;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff > {1'b0, v_ff}) begin
               u_in = u_ff - {1'b0, v_ff};
            end else begin
               v_in = v_ff - u_ff[P-1:0];
            end
         end
         rau_pkg::S_DIVT: begin
            if (div_done) begin
               qtop_in      = div_quo;
               div_start    = 1'b1;
               div_dividend = {1'b0, bot_ff};
               div_divisor  = g_ff;
            end
         end
         rau_pkg::S_DIVB: begin
            if (div_done) begin
               res_in = '0;
               if (qtop_ff[N-1:W] != '0 || div_quo[N-1:W] != '0) begin
                  res_in.status = rau_pkg::STAT_OVF;
               end else begin
                  res_in.res_negative = neg_ff;
                  res_in.res_top      = 32'(qtop_ff[W-1:0]);
                  res_in.res_bottom   = 32'(div_quo[W-1:0]);
               end
            end
         end
         rau_pkg::S_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rau_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; an_ff <= an_in; bn_ff <= bn_in; neg_ff <= neg_in;
      zden_ff <= zden_in;
      at_ff <= at_in; ab_ff <= ab_in; bt_ff <= bt_in; bb_ff <= bb_in;
      x_ff <= x_in; y_ff <= y_in; bot_ff <= bot_in; v_ff <= v_in; g_ff <= g_in;
      num_ff <= num_in; u_ff <= u_in; qtop_ff <= qtop_in; k_ff <= k_in;
      res_ff <= res_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == rau_pkg::S_MUL0)
      else $error("accepted request did not start work");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.status != 2'd3)
      else $error("illegal status code");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == rau_pkg::S_DIVT || state_ff == rau_pkg::S_DIVB))
      else $error("divider finished outside a division step");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_ITEMS = 1600;
   localparam int QUIET_ITEMS = 200;
   localparam int STUCK_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 400;

   class rational_scoreboard;
      rau_pkg::rsp_type pending_results[$];
      int errors = 0;

      function automatic logic [64:0] gcd65(logic [64:0] x, logic [64:0] y);
         logic [64:0] t;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         return x;
      endfunction

      function automatic rau_pkg::rsp_type reduce(logic neg, logic [64:0] num,
                                                  logic [63:0] den);
         rau_pkg::rsp_type o;
         logic [64:0] g;
         logic [64:0] t;
         logic [64:0] d;
         o = '0;
         if (num == 0) begin
            o.res_bottom = 32'd1;
            return o;
         end
         g = gcd65(num, {1'b0, den});
         t = num / g;
         d = {1'b0, den} / g;
         if ((t >> 32) != 0 || (d >> 32) != 0) begin
            o.status = rau_pkg::STAT_OVF;
            return o;
         end
         o.res_negative = neg;
         o.res_top = t[31:0];
         o.res_bottom = d[31:0];
         return o;
      endfunction

      function automatic rau_pkg::rsp_type rational_result(rau_pkg::req_type r);
         rau_pkg::rsp_type o;
         logic an, bn, neg;
         logic [31:0] at, ab, bt, bb;
         logic [63:0] x, y;
         logic [64:0] num;
         o = '0;
         an = r.a_negative;
         bn = r.b_negative;
         at = r.a_top;
         ab = r.a_bottom;
         bt = r.b_top;
         bb = r.b_bottom;
         if (r.cmd > rau_pkg::CMD_EQ) return o;
         if (ab == 0 || bb == 0) begin
            o.status = rau_pkg::STAT_DIV0;
            return o;
         end
         if (at == 0) begin
            an = 1'b0;
            ab = 32'd1;
         end
         if (bt == 0) begin
            bn = 1'b0;
            bb = 32'd1;
         end
         x = 64'(at) * 64'(bb);
         y = 64'(bt) * 64'(ab);
         case (r.cmd)
            rau_pkg::CMD_ADD: begin
               if (an == bn) begin
                  num = {1'b0, x} + {1'b0, y};
                  neg = an;
               end else if (x >= y) begin
                  num = {1'b0, x - y};
                  neg = an;
               end else begin
                  num = {1'b0, y - x};
                  neg = bn;
               end
               o = reduce(neg, num, 64'(ab) * 64'(bb));
            end
            rau_pkg::CMD_MUL: o = reduce(an ^ bn, {1'b0, 64'(at) * 64'(bt)},
                                         64'(ab) * 64'(bb));
            rau_pkg::CMD_DIV: begin
               if (bt == 0) o.status = rau_pkg::STAT_DIV0;
               else o = reduce(an ^ bn, {1'b0, x}, 64'(ab) * 64'(bt));
            end
            rau_pkg::CMD_LT: begin
               if (an != bn) o.truth = an;
               else if (an) o.truth = x > y;
               else o.truth = x < y;
            end
            default: o.truth = (an == bn) && (x == y);
         endcase
         return o;
      endfunction

      function void note_request(rau_pkg::req_type r);
         pending_results.push_back(rational_result(r));
      endfunction

      function void check_result(rau_pkg::rsp_type got);
         rau_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer %h", got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.res_negative !== want.res_negative) begin
            $error("res_negative: expected %0d, got %0d", want.res_negative, got.res_negative);
            errors++;
         end
         if (got.res_top !== want.res_top) begin
            $error("res_top: expected %0d, got %0d", want.res_top, got.res_top);
            errors++;
         end
         if (got.res_bottom !== want.res_bottom) begin
            $error("res_bottom: expected %0d, got %0d", want.res_bottom, got.res_bottom);
            errors++;
         end
         if (got.truth !== want.truth) begin
            $error("truth: expected %0d, got %0d", want.truth, got.truth);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rau_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rau_pkg::rsp_type rsp_data;

   rational_scoreboard board = new();
   bit idling = 1'b1;
   int stall_left = 0;
   int stuck_cycles = 0;

   always #5 clock = ~clock;

   rational_arithmetic_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (reset || !idling) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic logic [31:0] random_magnitude();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1, 2, 3: return $urandom_range(1, 12);
         4, 5: return $urandom_range(1, 1000);
         6: return $urandom_range(1, 65535);
         7: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   function automatic rau_pkg::req_type operation(logic [2:0] cmd, logic an,
                                                  logic [31:0] at, logic [31:0] ab,
                                                  logic bn, logic [31:0] bt,
                                                  logic [31:0] bb);
      rau_pkg::req_type r;
      r.cmd = cmd;
      r.a_negative = an;
      r.a_top = at;
      r.a_bottom = ab;
      r.b_negative = bn;
      r.b_top = bt;
      r.b_bottom = bb;
      return r;
   endfunction

   task automatic send(rau_pkg::req_type r);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   initial begin
      rau_pkg::req_type r;
      logic [31:0] k;
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int c = int'(rau_pkg::CMD_ADD); c <= int'(rau_pkg::CMD_EQ); c++) begin
         send(operation(3'(c), 1'b0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'd1));
         send(operation(3'(c), 1'b1, 32'd6, 32'd4, 1'b0, 32'd3, 32'd2));
         send(operation(3'(c), 1'b1, 32'd0, 32'd7, 1'b0, 32'd0, 32'hFFFF_FFFF));
      end
      send(operation(rau_pkg::CMD_ADD, 1'b0, 32'd1, 32'd0, 1'b0, 32'd1, 32'd1));
      send(operation(rau_pkg::CMD_EQ, 1'b0, 32'd1, 32'd1, 1'b1, 32'd1, 32'd0));
      send(operation(rau_pkg::CMD_DIV, 1'b1, 32'd5, 32'd3, 1'b1, 32'd0, 32'd9));
      send(operation(rau_pkg::CMD_ADD, 1'b1, 32'd5, 32'd3, 1'b0, 32'd5, 32'd3));
      send(operation(rau_pkg::CMD_MUL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'd1,
                     32'hFFFF_FFFF));
      send(operation(rau_pkg::CMD_DIV, 1'b0, 32'd1, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF,
                     32'd1));
      send(operation(rau_pkg::CMD_LT, 1'b1, 32'd0, 32'd3, 1'b0, 32'd0, 32'd5));
      send(operation(3'd5, 1'b1, 32'd1, 32'd1, 1'b1, 32'd1, 32'd1));
      send(operation(3'd7, 1'b1, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd0));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - QUIET_ITEMS) idling = 1'b0;
         r.cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
         r.a_negative = 1'($urandom_range(0, 1));
         r.b_negative = 1'($urandom_range(0, 1));
         r.a_top = random_magnitude();
         r.b_top = random_magnitude();
         r.a_bottom = random_magnitude();
         r.b_bottom = random_magnitude();
         if (r.a_bottom == 0 && $urandom_range(0, 3) != 0) r.a_bottom = 32'd1;
         if (r.b_bottom == 0 && $urandom_range(0, 3) != 0) r.b_bottom = 32'd1;
         if ($urandom_range(0, 5) == 0) begin
            // common factor so reduction has work to do
            k = $urandom_range(2, 300);
            r.a_top = r.a_top * k;
            r.a_bottom = (r.a_bottom == 0) ? 32'd0 : r.a_bottom * k;
         end
         if ($urandom_range(0, 7) == 0) begin
            r.b_top = r.a_top;
            r.b_bottom = r.a_bottom;
         end
         send(r);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (board.pending_results.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_results.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

### files.f
sv/rau_pkg.sv
sv/rau_mul.sv
sv/rau_div.sv
sv/rational_arithmetic_unit.sv
tb/testbench.sv
